FILE: sv/cel_pkg.sv
// Types, constants and helper functions shared by the calculator expression lexer.
package cel_pkg;

  localparam int MAX_LEXEME_LEN = 32;
  localparam int POSITION_BITS  = 16;
  localparam int LEN_W          = $clog2(MAX_LEXEME_LEN);
  localparam int OUT_POS_W      = 16;
  localparam int OUT_LEN_W      = 5;
  localparam int OUT_LEN_MAX    = 31;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = 2;

  localparam logic [LEN_W-1:0]         LEN_CAP = LEN_W'(MAX_LEXEME_LEN - 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_P  = 8'h70;
  localparam logic [7:0] CH_LOW_I  = 8'h69;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_PAREN = 3'd1,
    MODE_ALPHA = 3'd2,
    MODE_DIGIT = 3'd3,
    MODE_INT   = 3'd4,
    MODE_POINT = 3'd5,
    MODE_FRAC  = 3'd6
  } scan_mode_t;

  typedef enum logic [3:0] {
    K_PLUS   = 4'd0,
    K_MINUS  = 4'd1,
    K_DIV    = 4'd2,
    K_MUL    = 4'd3,
    K_POWER  = 4'd4,
    K_CALL   = 4'd5,
    K_END    = 4'd6,
    K_E      = 4'd7,
    K_PI     = 4'd8,
    K_NAME   = 4'd9,
    K_NUMBER = 4'd10,
    K_ERROR  = 4'd11
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_PAREN   = 2'd2,
    ERR_NUMBER  = 2'd3
  } error_kind_t;

  typedef enum logic [1:0] {
    KW_NONE = 2'd0,
    KW_E    = 2'd1,
    KW_P    = 2'd2,
    KW_PI   = 2'd3
  } keyword_t;

  typedef struct packed {
    token_kind_t            kind;
    logic [OUT_POS_W-1:0]   end_position;
    logic [OUT_LEN_W-1:0]   lexeme_length;
    error_kind_t            err;
    logic [7:0]             err_char;
    logic                   last;
  } token_t;

  typedef struct packed {
    logic             emit;
    token_t           tok;
    scan_mode_t       mode;
    logic [LEN_W-1:0] count;
    keyword_t         kw;
  } start_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [OUT_POS_W-1:0] sat_pos(logic [POSITION_BITS-1:0] p);
    return (p > POSITION_BITS'({OUT_POS_W{1'b1}})) ? '1 : OUT_POS_W'(p);
  endfunction

  function automatic logic [OUT_LEN_W-1:0] sat_len(logic [LEN_W-1:0] n);
    return (n > LEN_W'(OUT_LEN_MAX)) ? OUT_LEN_W'(OUT_LEN_MAX) : OUT_LEN_W'(n);
  endfunction

  function automatic token_t make_tok(token_kind_t k, logic [POSITION_BITS-1:0] p,
                                      logic [LEN_W-1:0] n, error_kind_t e,
                                      logic [7:0] c);
    token_t t;
    t.kind          = k;
    t.end_position  = sat_pos(p);
    t.lexeme_length = sat_len(n);
    t.err           = e;
    t.err_char      = (e != ERR_NONE) ? c : 8'h00;
    t.last          = 1'b0;
    return t;
  endfunction

  // A character seen where a token may begin.
  function automatic start_t start_token(logic [7:0] c, logic [POSITION_BITS-1:0] cur);
    start_t s;
    s.emit  = 1'b0;
    s.tok   = make_tok(K_PLUS, cur, '0, ERR_NONE, c);
    s.mode  = MODE_IDLE;
    s.count = '0;
    s.kw    = KW_NONE;
    case (c)
      CH_SPACE, CH_TAB: ;
      CH_PLUS: begin
        s.emit = 1'b1;
      end
      CH_MINUS: begin
        s.emit = 1'b1;
        s.tok  = make_tok(K_MINUS, cur, '0, ERR_NONE, c);
      end
      CH_SLASH: begin
        s.emit = 1'b1;
        s.tok  = make_tok(K_DIV, cur, '0, ERR_NONE, c);
      end
      CH_STAR: begin
        s.emit = 1'b1;
        s.tok  = make_tok(K_MUL, cur, '0, ERR_NONE, c);
      end
      CH_CARET: begin
        s.emit = 1'b1;
        s.tok  = make_tok(K_POWER, cur, '0, ERR_NONE, c);
      end
      CH_NL: begin
        s.emit = 1'b1;
        s.tok  = make_tok(K_END, cur, '0, ERR_NONE, c);
      end
      CH_LPAREN: begin
        s.mode = MODE_PAREN;
      end
      default: begin
        if (is_alpha(c)) begin
          s.mode  = MODE_ALPHA;
          s.count = LEN_W'(1);
          s.kw    = (to_lower(c) == CH_LOW_E) ? KW_E :
                    ((to_lower(c) == CH_LOW_P) ? KW_P : KW_NONE);
        end else if (is_digit(c)) begin
          s.mode  = MODE_INT;
          s.count = LEN_W'(1);
        end else begin
          s.emit = 1'b1;
          s.tok  = make_tok(K_ERROR, cur, '0, ERR_UNKNOWN, c);
        end
      end
    endcase
    return s;
  endfunction

endpackage

FILE: sv/calculator_expression_lexer_top.sv
// Calculator expression lexer: one character per word in, tokens out.
// An accepted character is registered; its tokens then enter the result queue.
// Throughput: one character per cycle while the four-entry result queue has room;
// a character completing two tokens pushes both; input stalls when nearly full.
// Reset clears the scan state, the character position and the result queue.
module calculator_expression_lexer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] end_position, [20:16] lexeme_length,
                                 // [22:21] error_kind, [30:23] error_char, [31] zero
  output logic [3:0]  m_tuser,   // [3:0] token_kind
  output logic        m_tlast    // last token caused by the character
);
  import cel_pkg::*;

  logic                     in_valid;
  logic [7:0]               in_char;
  scan_mode_t               mode, mode_next;
  logic [LEN_W-1:0]         count, count_next;
  logic [POSITION_BITS-1:0] char_pos, char_pos_next;
  keyword_t                 kw, kw_next;

  token_t                   fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]       wr_ptr, rd_ptr;
  logic [FIFO_AW:0]         fill;

  logic                     advance, pop;
  logic                     a_valid, do_start;
  token_t                   tok_a, slot0, slot1;
  start_t                   st;
  logic [1:0]               n_push;
  logic [POSITION_BITS-1:0] cur;
  logic [7:0]               c;
  token_kind_t              name_k;

  assign advance  = in_valid && (fill <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign s_tready = !in_valid || advance;
  assign pop      = m_tvalid && m_tready;

  assign c   = in_char;
  assign cur = (char_pos == POS_MAX) ? POS_MAX : char_pos + 1'b1;
  assign st  = start_token(c, cur);

  always_comb begin
    if (kw == KW_E && count == LEN_W'(1)) begin
      name_k = K_E;
    end else if (kw == KW_PI && count == LEN_W'(2)) begin
      name_k = K_PI;
    end else begin
      name_k = K_NAME;
    end
  end

  always_comb begin
    mode_next  = mode;
    count_next = count;
    kw_next    = kw;
    a_valid    = 1'b0;
    do_start   = 1'b0;
    tok_a      = make_tok(K_NAME, char_pos, count, ERR_NONE, c);
    unique case (mode)
      MODE_PAREN: begin
        mode_next = MODE_IDLE;
        a_valid   = 1'b1;
        if (c == CH_RPAREN) begin
          tok_a = make_tok(K_CALL, cur, '0, ERR_NONE, c);
        end else begin
          tok_a = make_tok(K_ERROR, cur, '0, ERR_PAREN, c);
        end
      end
      MODE_ALPHA: begin
        if (is_alpha(c) && count < LEN_CAP) begin
          kw_next    = (kw == KW_P && count == LEN_W'(1) && to_lower(c) == CH_LOW_I) ?
                       KW_PI : KW_NONE;
          count_next = count + 1'b1;
        end else if (is_digit(c) && count < LEN_CAP) begin
          kw_next    = KW_NONE;
          count_next = count + 1'b1;
          mode_next  = MODE_DIGIT;
        end else begin
          a_valid  = 1'b1;
          tok_a    = make_tok(name_k, char_pos, count, ERR_NONE, c);
          do_start = 1'b1;
        end
      end
      MODE_DIGIT: begin
        if (is_digit(c) && count < LEN_CAP) begin
          count_next = count + 1'b1;
        end else begin
          a_valid  = 1'b1;
          do_start = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit(c) && count < LEN_CAP) begin
          count_next = count + 1'b1;
        end else if (c == CH_POINT && ({1'b0, count} + 2'd2) <= {1'b0, LEN_CAP}) begin
          count_next = count + 1'b1;
          mode_next  = MODE_POINT;
        end else begin
          a_valid  = 1'b1;
          tok_a    = make_tok(K_NUMBER, char_pos, count, ERR_NONE, c);
          do_start = 1'b1;
        end
      end
      MODE_POINT: begin
        if (is_digit(c)) begin
          count_next = count + 1'b1;
          mode_next  = MODE_FRAC;
        end else begin
          a_valid    = 1'b1;
          tok_a      = make_tok(K_ERROR, cur, '0, ERR_NUMBER, c);
          mode_next  = MODE_IDLE;
          count_next = '0;
          kw_next    = KW_NONE;
        end
      end
      MODE_FRAC: begin
        if (is_digit(c) && count < LEN_CAP) begin
          count_next = count + 1'b1;
        end else begin
          a_valid  = 1'b1;
          tok_a    = make_tok(K_NUMBER, char_pos, count, ERR_NONE, c);
          do_start = 1'b1;
        end
      end
      MODE_IDLE: begin
        do_start = 1'b1;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase
    if (do_start) begin
      mode_next  = st.mode;
      count_next = st.count;
      kw_next    = st.kw;
    end
  end

  always_comb begin
    slot0  = a_valid ? tok_a : st.tok;
    slot1  = st.tok;
    n_push = 2'd0;
    if (a_valid && do_start && st.emit) begin
      n_push     = 2'd2;
      slot1.last = 1'b1;
    end else if (a_valid || (do_start && st.emit)) begin
      n_push     = 2'd1;
      slot0.last = 1'b1;
    end
    if (!advance) begin
      n_push = 2'd0;
    end
  end

  assign char_pos_next = advance ? cur : char_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode     <= MODE_IDLE;
      count    <= '0;
      char_pos <= '0;
      kw       <= KW_NONE;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        mode  <= mode_next;
        count <= count_next;
        kw    <= kw_next;
      end
      char_pos <= char_pos_next;
      wr_ptr   <= wr_ptr + FIFO_AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_char <= s_tdata;
    end
    if (n_push != 2'd0) begin
      fifo[wr_ptr] <= slot0;
    end
    if (n_push == 2'd2) begin
      fifo[wr_ptr + 1'b1] <= slot1;
    end
  end

  assign m_tvalid = (fill != '0);
  assign m_tuser  = fifo[rd_ptr].kind;
  assign m_tlast  = fifo[rd_ptr].last;
  assign m_tdata  = {1'b0, fifo[rd_ptr].err_char, fifo[rd_ptr].err,
                     fifo[rd_ptr].lexeme_length, fifo[rd_ptr].end_position};

endmodule

FILE: tb/lexer_token_checker.sv
// Token predictor and scoreboard that watches both streams of the calculator expression lexer.
module lexer_token_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [15:0] end_position, [20:16] lexeme_length,
                                 // [22:21] error_kind, [30:23] error_char, [31] zero
  input  logic [3:0]  m_tuser,   // [3:0] token_kind
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  import cel_pkg::*;

  localparam int     LEX_CAP   = MAX_LEXEME_LEN - 1;
  localparam longint POS_LIMIT = (longint'(1) << POSITION_BITS) - 1;

  typedef struct {
    token_kind_t kind;
    logic [15:0] end_pos;
    logic [4:0]  len;
    error_kind_t err;
    logic [7:0]  err_char;
    logic        last;
  } lex_token_t;

  lex_token_t  expected_tokens[$];
  lex_token_t  exp_tok;
  scan_mode_t  mode;
  keyword_t    kw;
  int          lex_count;
  longint      char_pos;
  longint      prev_pos;
  longint      cur_pos;
  int          step_tokens;
  int          fails = 0;
  int          waiting = 0;
  logic [7:0]  ch;

  assign fail_count = fails;
  assign pending    = waiting;

  function automatic logic char_is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic char_is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function void push_token(token_kind_t k, longint pos, int len, error_kind_t e,
                           logic [7:0] c);
    lex_token_t t;
    t.kind     = k;
    t.end_pos  = (pos > 65535) ? 16'hFFFF : 16'(pos);
    t.len      = (len > 31) ? 5'd31 : 5'(len);
    t.err      = e;
    t.err_char = (e != ERR_NONE) ? c : 8'h00;
    t.last     = 1'b0;
    expected_tokens.push_back(t);
    step_tokens++;
  endfunction

  // A character seen where a new token may begin.
  function void begin_token(logic [7:0] c, longint pos);
    mode      = MODE_IDLE;
    lex_count = 0;
    kw        = KW_NONE;
    case (c)
      CH_SPACE, CH_TAB: ;
      CH_PLUS:   push_token(K_PLUS, pos, 0, ERR_NONE, c);
      CH_MINUS:  push_token(K_MINUS, pos, 0, ERR_NONE, c);
      CH_SLASH:  push_token(K_DIV, pos, 0, ERR_NONE, c);
      CH_STAR:   push_token(K_MUL, pos, 0, ERR_NONE, c);
      CH_CARET:  push_token(K_POWER, pos, 0, ERR_NONE, c);
      CH_NL:     push_token(K_END, pos, 0, ERR_NONE, c);
      CH_LPAREN: mode = MODE_PAREN;
      default: begin
        if (char_is_letter(c)) begin
          mode      = MODE_ALPHA;
          lex_count = 1;
          if (fold_case(c) == CH_LOW_E) kw = KW_E;
          else if (fold_case(c) == CH_LOW_P) kw = KW_P;
        end else if (char_is_numeral(c)) begin
          mode      = MODE_INT;
          lex_count = 1;
        end else begin
          push_token(K_ERROR, pos, 0, ERR_UNKNOWN, c);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode      = MODE_IDLE;
      kw        = KW_NONE;
      lex_count = 0;
      char_pos  = 0;
      expected_tokens.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_tokens.size() == 0) begin
          fails++;
          $error("unexpected token: kind %0d end_position %0d", m_tuser, m_tdata[15:0]);
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (m_tuser != exp_tok.kind) begin
            fails++;
            $error("token_kind: expected %0d, actual %0d", exp_tok.kind, m_tuser);
          end
          if (m_tdata[15:0] != exp_tok.end_pos) begin
            fails++;
            $error("end_position: expected %0d, actual %0d", exp_tok.end_pos,
                   m_tdata[15:0]);
          end
          if (m_tdata[20:16] != exp_tok.len) begin
            fails++;
            $error("lexeme_length: expected %0d, actual %0d", exp_tok.len,
                   m_tdata[20:16]);
          end
          if (m_tdata[22:21] != exp_tok.err) begin
            fails++;
            $error("error_kind: expected %0d, actual %0d", exp_tok.err, m_tdata[22:21]);
          end
          if (m_tdata[30:23] != exp_tok.err_char) begin
            fails++;
            $error("error_char: expected %0d, actual %0d", exp_tok.err_char,
                   m_tdata[30:23]);
          end
          if (m_tlast != exp_tok.last) begin
            fails++;
            $error("last: expected %0d, actual %0d", exp_tok.last, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        ch          = s_tdata;
        step_tokens = 0;
        prev_pos    = char_pos;
        char_pos    = (prev_pos >= POS_LIMIT) ? POS_LIMIT : prev_pos + 1;
        cur_pos     = char_pos;
        case (mode)
          MODE_PAREN: begin
            mode = MODE_IDLE;
            if (ch == CH_RPAREN) push_token(K_CALL, cur_pos, 0, ERR_NONE, ch);
            else push_token(K_ERROR, cur_pos, 0, ERR_PAREN, ch);
          end
          MODE_ALPHA: begin
            if (char_is_letter(ch) && lex_count < LEX_CAP) begin
              kw = (kw == KW_P && lex_count == 1 && fold_case(ch) == CH_LOW_I) ?
                   KW_PI : KW_NONE;
              lex_count++;
            end else if (char_is_numeral(ch) && lex_count < LEX_CAP) begin
              kw = KW_NONE;
              lex_count++;
              mode = MODE_DIGIT;
            end else begin
              if (kw == KW_E && lex_count == 1)
                push_token(K_E, prev_pos, lex_count, ERR_NONE, ch);
              else if (kw == KW_PI && lex_count == 2)
                push_token(K_PI, prev_pos, lex_count, ERR_NONE, ch);
              else
                push_token(K_NAME, prev_pos, lex_count, ERR_NONE, ch);
              begin_token(ch, cur_pos);
            end
          end
          MODE_DIGIT: begin
            if (char_is_numeral(ch) && lex_count < LEX_CAP) begin
              lex_count++;
            end else begin
              push_token(K_NAME, prev_pos, lex_count, ERR_NONE, ch);
              begin_token(ch, cur_pos);
            end
          end
          MODE_INT: begin
            if (char_is_numeral(ch) && lex_count < LEX_CAP) begin
              lex_count++;
            end else if (ch == CH_POINT && lex_count + 2 <= LEX_CAP) begin
              lex_count++;
              mode = MODE_POINT;
            end else begin
              push_token(K_NUMBER, prev_pos, lex_count, ERR_NONE, ch);
              begin_token(ch, cur_pos);
            end
          end
          MODE_POINT: begin
            if (char_is_numeral(ch)) begin
              lex_count++;
              mode = MODE_FRAC;
            end else begin
              push_token(K_ERROR, cur_pos, 0, ERR_NUMBER, ch);
              mode      = MODE_IDLE;
              lex_count = 0;
              kw        = KW_NONE;
            end
          end
          MODE_FRAC: begin
            if (char_is_numeral(ch) && lex_count < LEX_CAP) begin
              lex_count++;
            end else begin
              push_token(K_NUMBER, prev_pos, lex_count, ERR_NONE, ch);
              begin_token(ch, cur_pos);
            end
          end
          default: begin_token(ch, cur_pos);
        endcase
        if (step_tokens > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      end
    end
    waiting = expected_tokens.size();
  end

endmodule

FILE: tb/tb_calculator_expression_lexer_top.sv
// Testbench top: drives characters into the lexer, stalls its output and reports the verdict.
module tb_calculator_expression_lexer_top;
  import cel_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 5000;
  localparam int PHASE_CHARS    = 500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  int   fail_count;
  int   pending;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   chars_sent = 0;
  int   quiet_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  string directed_chars = "+-/*^()E pI a1\t9.5*( 4.x";

  calculator_expression_lexer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  lexer_token_checker u_token_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Output side: random stalls, and one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_fragment();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 18) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 4);
      repeat (n) send_char(rand_letter());
    end else if (pick < 26) begin
      if ($urandom_range(1)) begin
        send_char($urandom_range(1) ? "e" : "E");
      end else begin
        send_char($urandom_range(1) ? "p" : "P");
        send_char($urandom_range(1) ? "i" : "I");
      end
    end else if (pick < 31) begin
      send_char(rand_letter());
      n = ($urandom_range(9) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 3);
      repeat (n) send_char(rand_digit());
    end else if (pick < 51) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(27, 33) : $urandom_range(1, 3);
      repeat (n) send_char(rand_digit());
      if ($urandom_range(1)) begin
        send_char(CH_POINT);
        n = ($urandom_range(7) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 3);
        repeat (n) send_char(rand_digit());
      end
    end else if (pick < 66) begin
      case ($urandom_range(4))
        0: send_char(CH_PLUS);
        1: send_char(CH_MINUS);
        2: send_char(CH_SLASH);
        3: send_char(CH_STAR);
        default: send_char(CH_CARET);
      endcase
    end else if (pick < 71) begin
      send_char(CH_LPAREN);
      send_char(CH_RPAREN);
    end else if (pick < 76) begin
      send_char(CH_NL);
    end else if (pick < 86) begin
      repeat ($urandom_range(1, 3)) send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
    end else if (pick < 90) begin
      send_char(CH_LPAREN);
      send_char(8'($urandom_range(255)));
    end else if (pick < 94) begin
      repeat ($urandom_range(1, 2)) send_char(rand_digit());
      send_char(CH_POINT);
      send_char(8'($urandom_range(255)));
    end else begin
      send_char(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int phase;
    int target;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed_chars.len(); i++) send_char(directed_chars[i]);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(CH_NL);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          src_idle_pct   = 70;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 70;
        end
        default: begin
          src_idle_pct   = 24;
          sink_stall_pct = 24;
        end
      endcase
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) send_fragment();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
